// ===== rtl/core/dfst_pkg.sv =====
package dfst_pkg;

   localparam int QUEUE_DEPTH = 8;
   localparam int QUEUE_AW    = 3;
   localparam int MAX_TOKENS  = 3;

   localparam logic [2:0] MODE_HEADER = 3'd0;
   localparam logic [2:0] MODE_STORED = 3'd1;
   localparam logic [2:0] MODE_FIXED  = 3'd2;
   localparam logic [2:0] MODE_END    = 3'd3;
   localparam logic [2:0] MODE_ERROR  = 3'd4;

   localparam logic [1:0] KIND_LITERAL = 2'd0;
   localparam logic [1:0] KIND_MATCH   = 2'd1;
   localparam logic [1:0] KIND_END     = 2'd2;
   localparam logic [1:0] KIND_ERROR   = 2'd3;

   localparam logic [2:0] FAULT_NONE      = 3'd0;
   localparam logic [2:0] FAULT_NLEN      = 3'd1;
   localparam logic [2:0] FAULT_BLOCK     = 3'd2;
   localparam logic [2:0] FAULT_CODE      = 3'd3;
   localparam logic [2:0] FAULT_DIST_SYM  = 3'd4;
   localparam logic [2:0] FAULT_RANGE     = 3'd5;

   localparam logic [1:0] PURP_LEN_EXTRA  = 2'd0;
   localparam logic [1:0] PURP_DIST_CODE  = 2'd1;
   localparam logic [1:0] PURP_DIST_EXTRA = 2'd2;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  lit;
      logic [8:0]  len;
      logic [15:0] distance;
      logic [2:0]  fault;
      logic        last;
   } token_type;

   typedef struct packed {
      logic [1:0]      cnt;
      token_type [2:0] tok;
   } push_type;

endpackage

// ===== rtl/core/dfst_core.sv =====
module dfst_core import dfst_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] in_byte,
   output push_type   push
);

   typedef struct packed {
      logic [2:0]  mode;
      logic [1:0]  hdr_cnt;
      logic        final_flag;
      logic        type_low;
      logic [15:0] st_cnt;
      logic [15:0] st_len;
      logic [7:0]  cmp_low;
      logic        st_len_valid;
      logic [8:0]  acc;
      logic [3:0]  code_cnt;
      logic [12:0] xv;
      logic [3:0]  xcnt;
      logic [3:0]  xtgt;
      logic [1:0]  purpose;
      logic [8:0]  plen;
      logic [15:0] pdist;
      logic [2:0]  fault;
   } state_type;

   typedef struct packed {
      state_type       st;
      token_type [2:0] tok;
      logic [1:0]      cnt;
   } ctx_type;

   state_type state_ff, state_in;
   ctx_type   c;

   function automatic ctx_type emit(ctx_type x, logic [1:0] k, logic [7:0] l,
                                    logic [8:0] n, logic [15:0] d, logic [2:0] f);
      if (x.cnt != 2'd3) begin
         x.tok[x.cnt].kind     = k;
         x.tok[x.cnt].lit      = l;
         x.tok[x.cnt].len      = n;
         x.tok[x.cnt].distance = d;
         x.tok[x.cnt].fault    = f;
         x.tok[x.cnt].last     = 1'b0;
         x.cnt = x.cnt + 2'd1;
      end
      return x;
   endfunction

   function automatic ctx_type fail(ctx_type x, logic [2:0] code);
      x.st.fault = code;
      x.st.mode  = MODE_ERROR;
      return emit(x, KIND_ERROR, 8'd0, 9'd0, 16'd0, code);
   endfunction

   function automatic ctx_type end_block(ctx_type x);
      x.st.hdr_cnt = 2'd0;
      if (x.st.final_flag) begin
         x.st.mode = MODE_END;
         x = emit(x, KIND_END, 8'd0, 9'd0, 16'd0, FAULT_NONE);
      end else begin
         x.st.mode = MODE_HEADER;
      end
      return x;
   endfunction

   function automatic ctx_type start_collect(ctx_type x, logic [1:0] p, logic [3:0] n);
      x.st.purpose = p;
      x.st.xtgt    = n;
      x.st.xcnt    = 4'd0;
      x.st.xv      = 13'd0;
      return x;
   endfunction

   function automatic ctx_type finish_match(ctx_type x);
      if (x.st.plen < 9'd3 || x.st.plen > 9'd258 ||
          x.st.pdist < 16'd1 || x.st.pdist > 16'd32768) begin
         x = fail(x, FAULT_RANGE);
      end else begin
         x = emit(x, KIND_MATCH, 8'd0, x.st.plen, x.st.pdist, FAULT_NONE);
      end
      return x;
   endfunction

   function automatic ctx_type header_bit(ctx_type x, logic b);
      logic [1:0] btype;
      if (x.st.hdr_cnt == 2'd0) begin
         x.st.final_flag = b;
         x.st.hdr_cnt    = 2'd1;
      end else if (x.st.hdr_cnt == 2'd1) begin
         x.st.type_low = b;
         x.st.hdr_cnt  = 2'd2;
      end else begin
         x.st.hdr_cnt = 2'd0;
         btype = {b, x.st.type_low};
         if (btype == 2'd0) begin
            x.st.mode         = MODE_STORED;
            x.st.st_len_valid = 1'b0;
            x.st.st_cnt       = 16'd0;
         end else if (btype == 2'd1) begin
            x.st.mode     = MODE_FIXED;
            x.st.acc      = 9'd0;
            x.st.code_cnt = 4'd0;
            x.st.xtgt     = 4'd0;
         end else begin
            x = fail(x, FAULT_BLOCK);
         end
      end
      return x;
   endfunction

   function automatic ctx_type handle_symbol(ctx_type x, logic [8:0] sym);
      logic [8:0] kw;
      logic [4:0] k;
      logic [2:0] grp;
      logic [2:0] nx;
      logic [9:0] lsum;
      kw = sym - 9'd257;
      k  = kw[4:0];
      grp = k[4:2];
      nx  = grp - 3'd1;
      lsum = (10'd2 << grp) + (10'(k[1:0]) << nx) + 10'd3;
      x.st.acc      = 9'd0;
      x.st.code_cnt = 4'd0;
      if (sym < 9'd256) begin
         x = emit(x, KIND_LITERAL, sym[7:0], 9'd0, 16'd0, FAULT_NONE);
      end else if (sym == 9'd256) begin
         x = end_block(x);
      end else if (sym > 9'd285) begin
         x = fail(x, FAULT_CODE);
      end else if (sym == 9'd285) begin
         x.st.plen = 9'd258;
         x = start_collect(x, PURP_DIST_CODE, 4'd5);
      end else if (k < 5'd8) begin
         x.st.plen = 9'(k) + 9'd3;
         x = start_collect(x, PURP_DIST_CODE, 4'd5);
      end else begin
         x.st.plen = lsum[8:0];
         x = start_collect(x, PURP_LEN_EXTRA, {1'b0, nx});
      end
      return x;
   endfunction

   function automatic ctx_type distance_symbol(ctx_type x, logic [12:0] sym);
      logic [3:0]  grp;
      logic [3:0]  nx;
      logic [16:0] dsum;
      grp  = sym[4:1];
      nx   = grp - 4'd1;
      dsum = (17'd1 << grp) + (17'(sym[0]) << nx) + 17'd1;
      if (sym > 13'd29) begin
         x = fail(x, FAULT_DIST_SYM);
      end else if (sym < 13'd4) begin
         x.st.pdist = 16'(sym) + 16'd1;
         x = finish_match(x);
      end else begin
         x.st.pdist = dsum[15:0];
         x = start_collect(x, PURP_DIST_EXTRA, nx);
      end
      return x;
   endfunction

   function automatic ctx_type fixed_bit(ctx_type x, logic b);
      logic [15:0] sh;
      logic [8:0]  a;
      sh = 16'(b) << x.st.xcnt;
      if (x.st.xtgt != 4'd0) begin
         if (x.st.purpose == PURP_DIST_CODE) x.st.xv = {x.st.xv[11:0], b};
         else x.st.xv = x.st.xv | sh[12:0];
         x.st.xcnt = x.st.xcnt + 4'd1;
         if (x.st.xcnt >= x.st.xtgt) begin
            x.st.xtgt = 4'd0;
            if (x.st.purpose == PURP_LEN_EXTRA) begin
               x.st.plen = x.st.plen + x.st.xv[8:0];
               x = start_collect(x, PURP_DIST_CODE, 4'd5);
            end else if (x.st.purpose == PURP_DIST_CODE) begin
               x = distance_symbol(x, x.st.xv);
            end else begin
               x.st.pdist = x.st.pdist + {3'd0, x.st.xv};
               x = finish_match(x);
            end
         end
      end else begin
         x.st.acc      = {x.st.acc[7:0], b};
         x.st.code_cnt = x.st.code_cnt + 4'd1;
         a = x.st.acc;
         if (x.st.code_cnt == 4'd7) begin
            if (a <= 9'h017) x = handle_symbol(x, 9'd256 + a);
         end else if (x.st.code_cnt == 4'd8) begin
            if (a inside {[9'h030:9'h0BF]}) x = handle_symbol(x, a - 9'h030);
            else if (a inside {[9'h0C0:9'h0C7]}) x = handle_symbol(x, a - 9'h0C0 + 9'd280);
         end else if (x.st.code_cnt >= 4'd9) begin
            // 9-bit literals 144..255 start at code 0x190
            if (a >= 9'h190) x = handle_symbol(x, a - 9'h100);
            else x = fail(x, FAULT_CODE);
         end
      end
      return x;
   endfunction

   function automatic ctx_type stored_byte(ctx_type x, logic [7:0] b);
      logic [15:0] nlen;
      nlen = {b, x.st.cmp_low};
      if (!x.st.st_len_valid) begin
         if (x.st.st_cnt == 16'd0) begin
            x.st.st_len = {8'd0, b};
            x.st.st_cnt = 16'd1;
         end else if (x.st.st_cnt == 16'd1) begin
            x.st.st_len = {b, x.st.st_len[7:0]};
            x.st.st_cnt = 16'd2;
         end else if (x.st.st_cnt == 16'd2) begin
            x.st.cmp_low = b;
            x.st.st_cnt  = 16'd3;
         end else if (~nlen != x.st.st_len) begin
            x = fail(x, FAULT_NLEN);
         end else begin
            x.st.st_len_valid = 1'b1;
            x.st.st_cnt       = 16'd0;
            if (x.st.st_len == 16'd0) begin
               x.st.st_len_valid = 1'b0;
               x = end_block(x);
            end
         end
      end else begin
         x = emit(x, KIND_LITERAL, b, 9'd0, 16'd0, FAULT_NONE);
         x.st.st_cnt = x.st.st_cnt + 16'd1;
         if (x.st.st_cnt >= x.st.st_len) begin
            x.st.st_len_valid = 1'b0;
            x.st.st_cnt       = 16'd0;
            x = end_block(x);
         end
      end
      return x;
   endfunction

   always_comb begin
      logic stop;
      stop  = 1'b0;
      c     = '0;
      c.st  = state_ff;
      if (state_ff.mode == MODE_END) begin
         c = emit(c, KIND_END, 8'd0, 9'd0, 16'd0, FAULT_NONE);
      end else if (state_ff.mode == MODE_ERROR) begin
         c = emit(c, KIND_ERROR, 8'd0, 9'd0, 16'd0, state_ff.fault);
      end else if (state_ff.mode == MODE_STORED) begin
         c = stored_byte(c, in_byte);
      end else begin
         // walk the byte LSB first; stop once the stream ends, faults or enters a stored block
         for (int i = 0; i < 8; i++) begin
            if (!stop) begin
               if (c.st.mode == MODE_HEADER) c = header_bit(c, in_byte[i]);
               else if (c.st.mode == MODE_FIXED) c = fixed_bit(c, in_byte[i]);
               else stop = 1'b1;
            end
         end
      end
      if (c.cnt != 2'd0) c.tok[c.cnt - 2'd1].last = 1'b1;
   end

   assign state_in = accept ? c.st : state_ff;
   assign push.cnt = accept ? c.cnt : 2'd0;
   assign push.tok = c.tok;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      ($past(state_ff.mode) == MODE_ERROR) |-> (state_ff.mode == MODE_ERROR))
      else $error("error mode left");
   a_end_sticky: assert property (@(posedge clock) disable iff (reset)
      ($past(state_ff.mode) == MODE_END) |-> (state_ff.mode == MODE_END))
      else $error("end mode left");
   a_error_fault: assert property (@(posedge clock) disable iff (reset)
      (state_ff.mode == MODE_ERROR) |-> (state_ff.fault != FAULT_NONE))
      else $error("error mode without fault code");

endmodule

// ===== rtl/core/dfst_queue.sv =====
module dfst_queue import dfst_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  push_type  push,
   input  logic      pop,
   output logic      can_accept,
   output logic      out_valid,
   output token_type out_tok
);

   token_type [QUEUE_DEPTH-1:0] mem_ff;
   logic [QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]   count_ff, count_in;
   logic                do_pop;

   assign do_pop     = pop && out_valid;
   assign out_valid  = count_ff != '0;
   assign out_tok    = mem_ff[rd_ptr_ff];
   assign can_accept = count_ff <= (QUEUE_AW+1)'(QUEUE_DEPTH - MAX_TOKENS);
   assign wr_ptr_in  = wr_ptr_ff + QUEUE_AW'(push.cnt);
   assign rd_ptr_in  = rd_ptr_ff + QUEUE_AW'(do_pop);
   assign count_in   = count_ff + (QUEUE_AW+1)'(push.cnt) - (QUEUE_AW+1)'(do_pop);

   always_ff @(posedge clock) begin
      for (int j = 0; j < MAX_TOKENS; j++) begin
         if (2'(j) < push.cnt) mem_ff[wr_ptr_ff + QUEUE_AW'(j)] <= push.tok[j];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (QUEUE_AW+1)'(QUEUE_DEPTH))
      else $error("queue overflow");
   a_room_for_push: assert property (@(posedge clock) disable iff (reset)
      (push.cnt != 2'd0) |-> (count_ff <= (QUEUE_AW+1)'(QUEUE_DEPTH - MAX_TOKENS)))
      else $error("push without room");
   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      QUEUE_AW'(wr_ptr_ff - rd_ptr_ff) == count_ff[QUEUE_AW-1:0])
      else $error("pointers disagree with count");

endmodule

// ===== rtl/core/deflate_fixed_stored_token_decoder.sv =====
// Tokens of an accepted byte are registered in the queue before any of them can leave it.
// Throughput: one byte per cycle while the token queue has room for three tokens;
// tokens drain at one per cycle while rsp_ready is high, so the token count per byte sets the sustained rate.
// The byte's bit walk is one combinational pass between the decode state and the queue.
// Reset (synchronous, active high) returns to block-header parsing and empties the queue.
module deflate_fixed_stored_token_decoder import dfst_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_token_kind,
   output logic [7:0]  rsp_literal_value,
   output logic [8:0]  rsp_match_length,
   output logic [15:0] rsp_match_distance,
   output logic [2:0]  rsp_fault_code,
   output logic        rsp_last_of_run
);

   push_type  push;
   token_type tok;
   logic      accept;

   assign accept = req_valid && req_ready;

   dfst_core u_core (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .in_byte (req_in_byte),
      .push    (push)
   );

   dfst_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .pop        (rsp_ready),
      .can_accept (req_ready),
      .out_valid  (rsp_valid),
      .out_tok    (tok)
   );

   assign rsp_token_kind     = tok.kind;
   assign rsp_literal_value  = tok.lit;
   assign rsp_match_length   = tok.len;
   assign rsp_match_distance = tok.distance;
   assign rsp_fault_code     = tok.fault;
   assign rsp_last_of_run    = tok.last;

endmodule
